// File: rtl/sitda_pkg.sv
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared constants and helpers for the signed integer to decimal text block.
// ----------------------------------------------------------------------------
package sitda_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int CHAR_W         = 6;
	// double-dabble shift steps folded into one pipeline stage
	localparam int DD_STEPS       = 4;

	localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

	// decimal digits of 2^(w-1), i.e. floor((w-1)*log10(2)) + 1, good for w up to 64
	function automatic int dec_digits(input int w);
		return ((w - 1) * 30103) / 100000 + 1;
	endfunction

endpackage

// File: rtl/sitda_serial.sv
// ----------------------------------------------------------------------------
// sitda_serial
// Holds one converted number and sends its text one character per cycle
// unless stalled: optional minus sign, then digits, top nonzero down to units.
// ----------------------------------------------------------------------------
module sitda_serial import sitda_pkg::*; #(
	parameter int ND    = dec_digits(DATA_WIDTH_DEF),
	parameter int IDX_W = $clog2(ND)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              src_valid,
	input  logic              src_neg,
	input  logic [4*ND-1:0]   src_bcd,
	input  logic [IDX_W-1:0]  src_top,
	output logic              src_take,
	output logic [CHAR_W-1:0] character,
	output logic              last,
	output logic              character_valid,
	input  logic              character_stall
);

	logic              sv_vld_q;
	logic              sv_sign_q;
	logic [IDX_W-1:0]  sv_idx_q;
	logic [4*ND-1:0]   sv_bcd_q;
	logic              ov_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_q;

	logic [3:0]        cur_digit;
	logic [CHAR_W-1:0] cur_char;
	logic              cur_last;
	logic              fire;

	assign cur_digit = sv_bcd_q[4*sv_idx_q +: 4];
	assign cur_char  = sv_sign_q ? CHAR_MINUS : (CHAR_ZERO + {2'b00, cur_digit});
	assign cur_last  = !sv_sign_q && (sv_idx_q == '0);
	assign fire      = sv_vld_q && (!ov_q || !character_stall);
	assign src_take  = !sv_vld_q || (fire && cur_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sv_vld_q <= 1'b0;
			ov_q     <= 1'b0;
		end else begin
			if (src_take) begin
				sv_vld_q <= src_valid;
			end
			if (fire) begin
				ov_q <= 1'b1;
			end else if (!character_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (src_take) begin
			sv_sign_q <= src_neg;
			sv_idx_q  <= src_top;
			sv_bcd_q  <= src_bcd;
		end else if (fire) begin
			if (sv_sign_q) begin
				sv_sign_q <= 1'b0;
			end else begin
				sv_idx_q <= sv_idx_q - 1'b1;
			end
		end
		if (fire) begin
			char_q <= cur_char;
			last_q <= cur_last;
		end
	end

	assign character       = char_q;
	assign last            = last_q;
	assign character_valid = ov_q;

endmodule

// File: rtl/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Renders a signed integer as decimal ASCII text, one character per item out.
// ----------------------------------------------------------------------------
// Each input item is a DATA_WIDTH-bit two's complement integer; the block
// returns its decimal text as a run of output items, most significant first,
// with a leading '-' for negative values, no leading zeros, '0' for zero, and
// last set on the final character. The most negative value comes out exact.
// Conversion runs in a pipeline (sign/magnitude stage, ceil(DATA_WIDTH/4)
// double-dabble stages of up to four shift steps each, a leading-digit
// stage), so a new number can enter every cycle while the pipeline has room;
// the output side sends one character per cycle while not stalled, so a
// number occupies the output for its sign plus digit count, 1 to 11
// characters at DATA_WIDTH 32, and that character rate sets the sustained
// throughput.
module signed_int_to_decimal_ascii import sitda_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [DATA_WIDTH-1:0] value,
	input  logic                  value_valid,
	output logic                  value_stall,
	output logic [CHAR_W-1:0]     character,
	output logic                  last,
	output logic                  character_valid,
	input  logic                  character_stall
);

	localparam int ND    = dec_digits(DATA_WIDTH);
	localparam int BCD_W = 4 * ND;
	localparam int IDX_W = $clog2(ND);
	localparam int NSTG  = (DATA_WIDTH + DD_STEPS - 1) / DD_STEPS;

	// one double-dabble step: add 3 to digits of 5 and up, then shift in a bit
	function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] b, input logic bi);
		logic [BCD_W-1:0] a;
		a = b;
		for (int i = 0; i < ND; i++) begin
			if (a[4*i +: 4] >= 4'd5) begin
				a[4*i +: 4] = a[4*i +: 4] + 4'd3;
			end
		end
		return {a[BCD_W-2:0], bi};
	endfunction

	// stage 1: sign and magnitude
	logic                  vld_s1;
	logic                  neg_s1;
	logic [DATA_WIDTH-1:0] mag_s1;
	logic                  adv_s1;

	// double-dabble stages
	logic                  dd_vld_s [NSTG];
	logic                  dd_neg_s [NSTG];
	logic [BCD_W-1:0]      dd_bcd_s [NSTG];
	logic [DATA_WIDTH-1:0] dd_bin_s [NSTG];
	logic                  dd_adv   [NSTG];

	// leading-digit stage
	logic                  lz_vld_s;
	logic                  lz_neg_s;
	logic [BCD_W-1:0]      lz_bcd_s;
	logic [IDX_W-1:0]      lz_top_s;
	logic                  lz_adv;
	logic [IDX_W-1:0]      lz_top_n;
	logic                  ser_take;

	assign adv_s1      = !vld_s1 || dd_adv[0];
	assign value_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv_s1) begin
			vld_s1 <= value_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			neg_s1 <= value[DATA_WIDTH-1];
			mag_s1 <= value[DATA_WIDTH-1] ? (~value + 1'b1) : value;
		end
	end

	for (genvar k = 0; k < NSTG; k++) begin : g_dd
		localparam int NSTEP = (DATA_WIDTH - k * DD_STEPS < DD_STEPS) ?
			(DATA_WIDTH - k * DD_STEPS) : DD_STEPS;

		logic                  src_vld;
		logic                  src_neg;
		logic [BCD_W-1:0]      src_bcd;
		logic [DATA_WIDTH-1:0] src_bin;
		logic                  nxt_adv;
		logic [BCD_W-1:0]      bcd_n;
		logic [DATA_WIDTH-1:0] bin_n;

		if (k == 0) begin : g_src_first
			assign src_vld = vld_s1;
			assign src_neg = neg_s1;
			assign src_bcd = '0;
			assign src_bin = mag_s1;
		end else begin : g_src_prev
			assign src_vld = dd_vld_s[k-1];
			assign src_neg = dd_neg_s[k-1];
			assign src_bcd = dd_bcd_s[k-1];
			assign src_bin = dd_bin_s[k-1];
		end

		if (k == NSTG - 1) begin : g_nxt_lz
			assign nxt_adv = lz_adv;
		end else begin : g_nxt_dd
			assign nxt_adv = dd_adv[k+1];
		end

		assign dd_adv[k] = !dd_vld_s[k] || nxt_adv;

		always_comb begin
			bcd_n = src_bcd;
			bin_n = src_bin;
			for (int j = 0; j < NSTEP; j++) begin
				bcd_n = dd_step(bcd_n, bin_n[DATA_WIDTH-1]);
				bin_n = {bin_n[DATA_WIDTH-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dd_vld_s[k] <= 1'b0;
			end else if (dd_adv[k]) begin
				dd_vld_s[k] <= src_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (dd_adv[k]) begin
				dd_neg_s[k] <= src_neg;
				dd_bcd_s[k] <= bcd_n;
				dd_bin_s[k] <= bin_n;
			end
		end
	end

	// highest nonzero digit, units digit when the value is zero
	always_comb begin
		lz_top_n = '0;
		for (int i = 0; i < ND; i++) begin
			if (dd_bcd_s[NSTG-1][4*i +: 4] != 4'd0) begin
				lz_top_n = IDX_W'(i);
			end
		end
	end

	assign lz_adv = !lz_vld_s || ser_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lz_vld_s <= 1'b0;
		end else if (lz_adv) begin
			lz_vld_s <= dd_vld_s[NSTG-1];
		end
	end

	always_ff @(posedge clk) begin
		if (lz_adv) begin
			lz_neg_s <= dd_neg_s[NSTG-1];
			lz_bcd_s <= dd_bcd_s[NSTG-1];
			lz_top_s <= lz_top_n;
		end
	end

	sitda_serial #(
		.ND    (ND),
		.IDX_W (IDX_W)
	) u_serial (
		.clk             (clk),
		.arst_n          (arst_n),
		.src_valid       (lz_vld_s),
		.src_neg         (lz_neg_s),
		.src_bcd         (lz_bcd_s),
		.src_top         (lz_top_s),
		.src_take        (ser_take),
		.character       (character),
		.last            (last),
		.character_valid (character_valid),
		.character_stall (character_stall)
	);

endmodule

// File: rtl/sitda_check.sv
// ----------------------------------------------------------------------------
// sitda_check
// Port-level checks on the character stream of the decimal text block.
// ----------------------------------------------------------------------------
module sitda_check import sitda_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic [CHAR_W-1:0] character,
	input logic              last,
	input logic              character_valid,
	input logic              character_stall
);

	logic first_q;
	logic after_minus_q;
	logic take;

	assign take = character_valid && !character_stall;

	// track where in a number's text the next item falls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q       <= 1'b1;
			after_minus_q <= 1'b0;
		end else if (take) begin
			first_q       <= last;
			after_minus_q <= (character == CHAR_MINUS);
		end
	end

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		character_valid && character_stall |=> character_valid)
		else $error("character valid dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		character_valid && character_stall |=> $stable(character) && $stable(last))
		else $error("character changed while stalled");

	a_legal_char: assert property (@(posedge clk) disable iff (!arst_n)
		character_valid |-> (character == CHAR_MINUS) ||
			((character >= CHAR_ZERO) && (character <= CHAR_ZERO + 6'd9)))
		else $error("character outside minus and digits");

	a_minus_first: assert property (@(posedge clk) disable iff (!arst_n)
		character_valid && (character == CHAR_MINUS) |-> first_q && !last)
		else $error("minus sign not at start of a number or ends it");

	a_no_lead_zero: assert property (@(posedge clk) disable iff (!arst_n)
		character_valid && (first_q || after_minus_q) && (character == CHAR_ZERO)
			|-> last && !after_minus_q)
		else $error("leading zero in number text");

endmodule

bind signed_int_to_decimal_ascii sitda_check u_sitda_check (
	.clk             (clk),
	.arst_n          (arst_n),
	.character       (character),
	.last            (last),
	.character_valid (character_valid),
	.character_stall (character_stall)
);

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Random and directed test of signed_int_to_decimal_ascii: integers go in, a
// scoreboard renders each one as decimal text and compares every character
// and last flag that comes out, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb;
	import sitda_pkg::*;

	localparam int RANDOM_ITEMS = 370;
	localparam int PHASE_ITEMS  = 40;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int SETTLE       = 40;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} text_char_t;

	class decimal_text_scoreboard;
		text_char_t text_q[$];
		int         mismatches;

		function new();
			mismatches = 0;
		endfunction

		function int pending();
			return text_q.size();
		endfunction

		// render the accepted number as its expected characters
		function void note_value(logic [DATA_WIDTH_DEF-1:0] v);
			logic [DATA_WIDTH_DEF:0] mag;
			logic [3:0]              digs[$];
			logic                    neg;
			text_char_t              c;
			neg = v[DATA_WIDTH_DEF-1];
			// one bit wider so the most negative value keeps its magnitude
			mag = neg ? ({(DATA_WIDTH_DEF+1){1'b0}} - {v[DATA_WIDTH_DEF-1], v}) : {1'b0, v};
			do begin
				digs.push_front(4'(mag % 10));
				mag = mag / 10;
			end while (mag != 0);
			if (neg) begin
				c.ch   = CHAR_MINUS;
				c.last = 1'b0;
				text_q.push_back(c);
			end
			foreach (digs[i]) begin
				c.ch   = CHAR_ZERO + CHAR_W'(digs[i]);
				c.last = (i == digs.size() - 1);
				text_q.push_back(c);
			end
		endfunction

		function void check_char(logic [CHAR_W-1:0] ch, logic lst);
			text_char_t want;
			if (text_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("character %0d last %0b arrived with nothing expected", ch, lst);
				return;
			end
			want = text_q.pop_front();
			if (ch !== want.ch || lst !== want.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("character mismatch: expected %0d last %0b, got %0d last %0b",
						want.ch, want.last, ch, lst);
			end
		endfunction
	endclass

	logic                      clk;
	logic                      arst_n;
	logic [DATA_WIDTH_DEF-1:0] value;
	logic                      value_valid;
	logic                      value_stall;
	logic [CHAR_W-1:0]         character;
	logic                      last;
	logic                      character_valid;
	logic                      character_stall;

	decimal_text_scoreboard sb;
	bit                     steady;
	int                     cycle_count;

	signed_int_to_decimal_ascii u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.value           (value),
		.value_valid     (value_valid),
		.value_stall     (value_stall),
		.character       (character),
		.last            (last),
		.character_valid (character_valid),
		.character_stall (character_stall)
	);

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// steady stretches run with no idling on either side
	function automatic int draw_gap();
		return steady ? 0 : $urandom_range(0, 19);
	endfunction

	task automatic send_value(input logic [DATA_WIDTH_DEF-1:0] v);
		int gap;
		gap = draw_gap();
		if (gap != 0) begin
			value_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		value       <= v;
		value_valid <= 1'b1;
		@(posedge clk);
		while (value_stall) @(posedge clk);
		sb.note_value(v);
	endtask

	// hold off the sender until every character has come out
	task automatic drain_text();
		value_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	function automatic logic [DATA_WIDTH_DEF-1:0] rand_value();
		logic [DATA_WIDTH_DEF-1:0] v;
		int                        sel;
		int                        p;
		sel = $urandom_range(0, 3);
		p   = 1;
		case (sel)
			0: begin
				v = $urandom;
			end
			1: begin
				// spread over every text length
				v = $urandom >> $urandom_range(0, 31);
				if ($urandom_range(0, 1) == 1)
					v = -v;
			end
			2: begin
				// just around a power of ten
				repeat ($urandom_range(0, 9)) p = p * 10;
				v = DATA_WIDTH_DEF'(p) + $urandom_range(0, 2) - 1;
				if ($urandom_range(0, 1) == 1)
					v = -v;
			end
			default: begin
				v = $urandom_range(0, 40) - 20;
			end
		endcase
		return v;
	endfunction

	// output side
	initial begin
		int n;
		character_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			n = draw_gap();
			if (n != 0) begin
				character_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			character_stall <= 1'b0;
			@(posedge clk);
			while (!character_valid) @(posedge clk);
			sb.check_char(character, last);
		end
	end

	initial begin
		logic [DATA_WIDTH_DEF-1:0] directed[$];
		sb          = new();
		steady      = 1'b0;
		cycle_count = 0;
		arst_n      <= 1'b0;
		value       <= '0;
		value_valid <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// zero, single digits, ten boundaries, both extremes, alternating bits
		directed = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
			32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001, 32'd1000000000, 32'd999999999,
			-32'sd999999999, -32'sd1000000000, 32'd123456789, 32'h5555_5555,
			32'haaaa_aaaa, -32'sd5, 32'd7};
		foreach (directed[i])
			send_value(directed[i]);
		drain_text();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % PHASE_ITEMS == 0) begin
				if (i % (2 * PHASE_ITEMS) == 0)
					drain_text();
				steady = ($urandom_range(0, 3) == 0);
			end
			send_value(rand_value());
		end
		value_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (sb.mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/sitda_pkg.sv
rtl/sitda_serial.sv
rtl/signed_int_to_decimal_ascii.sv
rtl/sitda_check.sv
dv/tb.sv
